// ===== design/dangerous_import_signature_scan_unit_defines.svh =====
// assertion helpers used by the scan unit
`ifndef DANGEROUS_IMPORT_SIGNATURE_SCAN_UNIT_DEFINES_SVH
`define DANGEROUS_IMPORT_SIGNATURE_SCAN_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define DIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define DIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dis_pkg.sv =====
package dis_pkg;

    localparam int BYTE_W              = 8;
    localparam int SIG_TABLE_SIZE      = 8;
    localparam int SIG_MAX_LEN         = 23;
    localparam int SIG_LEN_W           = 5;
    localparam int THRESH_W            = 4;
    localparam int COUNT_W             = 4;
    localparam int DEF_WINDOW_BYTES    = 23;
    localparam int DEF_SIGNATURE_COUNT = 8;
    localparam int IN_TDATA_W          = 8;
    localparam int OUT_TDATA_W         = 16;

    typedef logic [BYTE_W-1:0]             t_byte;
    typedef logic [SIG_TABLE_SIZE-1:0]     t_sig_mask;
    typedef logic [THRESH_W-1:0]           t_thresh;
    typedef logic [COUNT_W-1:0]            t_count;
    typedef logic [SIG_MAX_LEN*BYTE_W-1:0] t_sig_text;
    typedef logic [SIG_LEN_W-1:0]          t_sig_len;

    localparam t_thresh THRESH_RESET = t_thresh'(3);

    // last character sits in the lowest byte, shorter names are zero padded on top
    localparam t_sig_text SIG_TEXT [SIG_TABLE_SIZE] = '{
        t_sig_text'("CreateRemoteThread"),
        t_sig_text'("NtCreateThreadEx"),
        t_sig_text'("RtlCreateUserThread"),
        t_sig_text'("SetWindowsHookEx"),
        t_sig_text'("VirtualProtectEx"),
        t_sig_text'("NtWriteVirtualMemory"),
        t_sig_text'("NtAllocateVirtualMemory"),
        t_sig_text'("ZwMapViewOfSection")
    };

    localparam t_sig_len SIG_LEN [SIG_TABLE_SIZE] = '{
        t_sig_len'(18), t_sig_len'(16), t_sig_len'(19), t_sig_len'(16),
        t_sig_len'(16), t_sig_len'(20), t_sig_len'(23), t_sig_len'(18)
    };

    function automatic t_count popcount(input t_sig_mask mask);
        t_count cnt;
        cnt = '0;
        for (int k = 0; k < SIG_TABLE_SIZE; k++) begin
            cnt = cnt + t_count'(mask[k]);
        end
        return cnt;
    endfunction

endpackage

// ===== design/dis_window.sv =====
module dis_window #(
    parameter int WINDOW_BYTES = dis_pkg::DEF_WINDOW_BYTES
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_shift,
    input  logic                                       i_clear,
    input  dis_pkg::t_byte                             i_byte,
    output logic [WINDOW_BYTES-2:0][dis_pkg::BYTE_W-1:0] o_hist
);
    import dis_pkg::*;

    localparam int HIST_DEPTH = WINDOW_BYTES - 1;

    logic [HIST_DEPTH-1:0][BYTE_W-1:0] r_hist;
    logic [HIST_DEPTH-1:0][BYTE_W-1:0] n_hist;

    always_comb begin
        n_hist = r_hist;
        if (i_clear) begin
            n_hist = '0;
        end else if (i_shift) begin
            n_hist[0] = i_byte;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                n_hist[i] = r_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else begin
            r_hist <= n_hist;
        end
    end

    assign o_hist = r_hist;

endmodule

// ===== design/dis_match.sv =====
module dis_match #(
    parameter int WINDOW_BYTES    = dis_pkg::DEF_WINDOW_BYTES,
    parameter int SIGNATURE_COUNT = dis_pkg::DEF_SIGNATURE_COUNT
) (
    input  dis_pkg::t_byte                               i_byte,
    input  logic [WINDOW_BYTES-2:0][dis_pkg::BYTE_W-1:0] i_hist,
    output dis_pkg::t_sig_mask                           o_hits
);
    import dis_pkg::*;

    localparam int HIST_DEPTH = WINDOW_BYTES - 1;

    // w_win[0] is the current byte, w_win[j] the byte j steps back
    t_byte w_win [SIG_MAX_LEN];

    genvar j;
    generate
        for (j = 0; j < SIG_MAX_LEN; j++) begin : g_win
            if (j == 0) begin : g_cur
                assign w_win[j] = i_byte;
            end else if (j <= HIST_DEPTH) begin : g_hist
                assign w_win[j] = i_hist[j-1];
            end else begin : g_none
                assign w_win[j] = '0;
            end
        end
    endgenerate

    always_comb begin
        o_hits = '0;
        for (int k = 0; k < SIG_TABLE_SIZE; k++) begin
            if (k < SIGNATURE_COUNT && int'(SIG_LEN[k]) <= WINDOW_BYTES) begin
                o_hits[k] = 1'b1;
                for (int p = 0; p < SIG_MAX_LEN; p++) begin
                    if (p < int'(SIG_LEN[k]) && w_win[p] != SIG_TEXT[k][p*BYTE_W +: BYTE_W]) begin
                        o_hits[k] = 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ===== design/dangerous_import_signature_scan_unit.sv =====
// datapath: a byte is taken into the input register and matched there against the first
// SIGNATURE_COUNT signatures that fit the window; a final byte loads the result register
// throughput: one byte per cycle; the single result register is the only stall point
// reset: synchronous active-low, clears the window, the found bits, both valid flags
// and sets the threshold to 3; history and found bits are cleared after every final byte
`include "dangerous_import_signature_scan_unit_defines.svh"

module dangerous_import_signature_scan_unit #(
    parameter int WINDOW_BYTES    = dis_pkg::DEF_WINDOW_BYTES,
    parameter int SIGNATURE_COUNT = dis_pkg::DEF_SIGNATURE_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  dis_pkg::t_thresh                 i_cfg_wr_data,   // alarm_threshold
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [dis_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // [7:0] data_byte
    input  logic                             i_s_axis_tlast,  // final_byte
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] detected, [4:1] match_count, [12:5] found_mask, [15:13] zero
    output logic [dis_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import dis_pkg::*;

    logic      r_in_valid;
    t_byte     r_in_byte;
    logic      r_in_last;
    t_thresh   r_threshold;
    t_sig_mask r_seen;
    t_sig_mask n_seen;
    logic      r_out_valid;
    logic      r_out_detected;
    t_count    r_out_count;
    t_sig_mask r_out_mask;
    t_count    w_count;
    t_sig_mask w_hits;
    logic      w_adv;

    logic [WINDOW_BYTES-2:0][BYTE_W-1:0] w_hist;

    // a non-final byte never needs the result slot
    assign w_adv           = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    dis_window #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_window (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_shift(w_adv),
        .i_clear(w_adv && r_in_last),
        .i_byte (r_in_byte),
        .o_hist (w_hist)
    );

    dis_match #(
        .WINDOW_BYTES   (WINDOW_BYTES),
        .SIGNATURE_COUNT(SIGNATURE_COUNT)
    ) u_match (
        .i_byte(r_in_byte),
        .i_hist(w_hist),
        .o_hits(w_hits)
    );

    assign n_seen  = r_seen | w_hits;
    assign w_count = popcount(n_seen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata[BYTE_W-1:0];
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_adv) begin
            r_seen <= r_in_last ? '0 : n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_detected <= (w_count >= r_threshold);
            r_out_count    <= w_count;
            r_out_mask     <= n_seen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 1 - COUNT_W - SIG_TABLE_SIZE){1'b0}},
                              r_out_mask, r_out_count, r_out_detected};

    `DIS_ASSERT_NOW(a_count_matches_mask, i_clk, i_rst_n, r_out_valid,
        $countones(r_out_mask) == int'(r_out_count), "match count disagrees with mask")

    `DIS_ASSERT_NOW(a_detect_vs_threshold, i_clk, i_rst_n, r_out_valid,
        r_out_detected == (r_out_count >= r_threshold), "detected flag disagrees with threshold")

    `DIS_ASSERT_NEXT(a_seen_cleared, i_clk, i_rst_n, w_adv && r_in_last,
        r_seen == '0, "found bits not cleared after final byte")

    `DIS_ASSERT_NOW(a_seen_in_range, i_clk, i_rst_n, 1'b1,
        (r_seen >> SIGNATURE_COUNT) == '0, "found bit set beyond signature count")

endmodule
